FILE: rtl/arp_cache_table_with_aging_macros.svh
// Assertion macros for the ARP cache table with aging.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ARP_CACHE_TABLE_WITH_AGING_MACROS_SVH
`define ARP_CACHE_TABLE_WITH_AGING_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define ARPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ARPC_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ARPC_ASSERT(label, clk, rst_n, prop, msg)
`define ARPC_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

FILE: rtl/arpc_pkg.sv
// Shared constants and types for the ARP cache table with aging.
// No dependencies; imported by arpc_match_unit, the top level and the testbench.
package arpc_pkg;

    localparam int DEPTH     = 32;
    localparam int MAC_BYTES = 6;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int IP_W      = 32;
    localparam int MAC_W     = MAC_BYTES * 8;
    localparam int TIME_W    = 32;
    localparam int REMOVED_W = 6;
    localparam int STATUS_W  = 2;
    localparam int MODE_W    = 2;

    localparam logic [TIME_W-1:0] AGE_LIMIT_RESET = TIME_W'(15);

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_AGE    = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the cache entries; no package dependencies.
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/arpc_match_unit.sv
// Shared compare unit: IP match for lookups, age test for sweeps.
// Depends on arpc_pkg for the entry type and field widths.
module arpc_match_unit
    import arpc_pkg::*;
(
    input  entry_t            entry,
    input  logic [IP_W-1:0]   key_ip,
    input  logic [TIME_W-1:0] now,
    input  logic [TIME_W-1:0] limit,
    input  logic              sel_age,
    output logic              flag
);

    logic [TIME_W-1:0] age;

    // Age wraps modulo 2^32.
    assign age  = now - entry.stamp;
    assign flag = sel_age ? (age >= limit) : (entry.ip == key_ip);

endmodule

FILE: rtl/arp_cache_table_with_aging.sv
// Top level of the ARP cache table with aging: sequencer, counters, result registers.
// Depends on arpc_pkg, arpc_ram, arpc_match_unit and the assertion macro header.
//
// Usage: drive mode, ip_addr, mac_addr and time_now with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
// Each transaction gives exactly one result, shown on status, found_ip,
// found_mac, found_stamp and removed_count for one cycle while done is high.
// The receiver cannot stall; the result must be captured in that cycle.
// Insert, insert when full, and a pop or lookup of an empty table finish
// straight from idle. A pop reads the newest entry in S_POP. A lookup probes
// up to N entries newest first, N being the entries held, and stops at the
// first IP match. An age sweep probes all N entries, or finishes straight from
// idle when the table is empty. Each entry probe uses the entry RAM's single
// read port in a read state, then the shared compare unit in a check state.
// busy stays high until done. age_limit is written through cfg_we and
// cfg_wdata; the user must write it only while the block is idle, as the
// block does not enforce this. Reset empties the table and loads an age limit
// of 15; entry contents are not cleared, the entry count alone marks what is valid.
`include "arp_cache_table_with_aging_macros.svh"

module arp_cache_table_with_aging
    import arpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [MODE_W-1:0]    mode,
    input  logic [IP_W-1:0]      ip_addr,
    input  logic [MAC_W-1:0]     mac_addr,
    input  logic [TIME_W-1:0]    time_now,
    input  logic                 cfg_we,
    input  logic [TIME_W-1:0]    cfg_wdata,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [IP_W-1:0]      found_ip,
    output logic [MAC_W-1:0]     found_mac,
    output logic [TIME_W-1:0]    found_stamp,
    output logic [REMOVED_W-1:0] removed_count
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LK_RD  = 3'd1;
    localparam logic [2:0] S_LK_CHK = 3'd2;
    localparam logic [2:0] S_POP    = 3'd3;
    localparam logic [2:0] S_SW_RD  = 3'd4;
    localparam logic [2:0] S_SW_CHK = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]     keep_reg, keep_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IP_W-1:0]      key_ip_reg, key_ip_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [TIME_W-1:0]    age_limit_reg;

    logic                 done_reg, done_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [IP_W-1:0]      found_ip_reg, found_ip_next;
    logic [MAC_W-1:0]     found_mac_reg, found_mac_next;
    logic [TIME_W-1:0]    found_stamp_reg, found_stamp_next;
    logic [REMOVED_W-1:0] removed_reg, removed_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               rd_entry;
    entry_t               new_entry;

    logic                 unit_sel_age;
    logic                 unit_flag;
    logic                 accept;
    logic                 sweep_last;
    logic [CNT_W-1:0]     keep_inc;

    assign accept    = start && !busy;
    assign rd_entry  = entry_t'(ram_rdata);
    assign new_entry = '{ip: ip_addr, mac: mac_addr, stamp: time_now};

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    arpc_match_unit u_match (
        .entry   (rd_entry),
        .key_ip  (key_ip_reg),
        .now     (now_reg),
        .limit   (age_limit_reg),
        .sel_age (unit_sel_age),
        .flag    (unit_flag)
    );

    assign unit_sel_age = (state_reg == S_SW_CHK);
    assign keep_inc     = keep_reg + CNT_W'(!unit_flag);
    assign sweep_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == total_reg);

    always_comb
    begin
        state_next       = state_reg;
        total_next       = total_reg;
        keep_next        = keep_reg;
        idx_next         = idx_reg;
        key_ip_next      = key_ip_reg;
        now_next         = now_reg;
        done_next        = 1'b0;
        status_next      = STATUS_OK;
        found_ip_next    = '0;
        found_mac_next   = '0;
        found_stamp_next = '0;
        removed_next     = '0;
        ram_we           = 1'b0;
        ram_waddr        = total_reg[IDX_W-1:0];
        ram_wdata        = ENTRY_W'(new_entry);
        // In idle, point at the newest entry so the registered read data holds it when a pop reaches S_POP.
        ram_raddr        = IDX_W'(total_reg - CNT_W'(1));

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_ip_next = ip_addr;
                    now_next    = time_now;
                    unique case (mode)
                        MODE_INSERT:
                        begin
                            done_next = 1'b1;
                            if (total_reg >= CNT_W'(DEPTH))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                total_next = total_reg + CNT_W'(1);
                            end
                        end
                        MODE_LOOKUP:
                        begin
                            if (total_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = STATUS_MISS;
                            end
                            else
                            begin
                                idx_next   = IDX_W'(total_reg - CNT_W'(1));
                                state_next = S_LK_RD;
                            end
                        end
                        MODE_POP:
                        begin
                            if (total_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = STATUS_MISS;
                            end
                            else
                            begin
                                total_next = total_reg - CNT_W'(1);
                                state_next = S_POP;
                            end
                        end
                        MODE_AGE:
                        begin
                            if (total_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                keep_next  = '0;
                                state_next = S_SW_RD;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            S_LK_RD:
            begin
                ram_raddr  = idx_reg;
                state_next = S_LK_CHK;
            end
            S_LK_CHK:
            begin
                if (unit_flag)
                begin
                    done_next        = 1'b1;
                    found_ip_next    = rd_entry.ip;
                    found_mac_next   = rd_entry.mac;
                    found_stamp_next = rd_entry.stamp;
                    state_next       = S_IDLE;
                end
                else if (idx_reg == '0)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_MISS;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = S_LK_RD;
                end
            end
            S_POP:
            begin
                done_next        = 1'b1;
                found_ip_next    = rd_entry.ip;
                found_mac_next   = rd_entry.mac;
                found_stamp_next = rd_entry.stamp;
                state_next       = S_IDLE;
            end
            S_SW_RD:
            begin
                ram_raddr  = idx_reg;
                state_next = S_SW_CHK;
            end
            S_SW_CHK:
            begin
                // Compact survivors down to the keep pointer, order preserved.
                if (!unit_flag)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = keep_reg[IDX_W-1:0];
                    ram_wdata = ram_rdata;
                end
                keep_next = keep_inc;
                if (sweep_last)
                begin
                    done_next    = 1'b1;
                    removed_next = REMOVED_W'(total_reg - keep_inc);
                    total_next   = keep_inc;
                    state_next   = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_SW_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            done_reg      <= 1'b0;
            age_limit_reg <= AGE_LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                age_limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        keep_reg        <= keep_next;
        idx_reg         <= idx_next;
        key_ip_reg      <= key_ip_next;
        now_reg         <= now_next;
        status_reg      <= status_next;
        found_ip_reg    <= found_ip_next;
        found_mac_reg   <= found_mac_next;
        found_stamp_reg <= found_stamp_next;
        removed_reg     <= removed_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign found_ip      = found_ip_reg;
    assign found_mac     = found_mac_reg;
    assign found_stamp   = found_stamp_reg;
    assign removed_count = removed_reg;

    `ARPC_NEVER(a_total_bound, clk, rst_n, total_reg > CNT_W'(DEPTH), "entry count above depth")
    `ARPC_ASSERT(a_done_idle, clk, rst_n, done_reg |-> (state_reg == S_IDLE), "done while busy")
    `ARPC_ASSERT(a_accept_progress, clk, rst_n, accept |=> (busy || done_reg), "transaction lost")
    `ARPC_ASSERT(a_keep_le_idx, clk, rst_n, (state_reg == S_SW_CHK) |-> (keep_reg <= CNT_W'(idx_reg)), "keep pointer ahead of scan")
    `ARPC_ASSERT(a_full_status, clk, rst_n, (done_reg && status_reg == STATUS_FULL) |-> (total_reg == CNT_W'(DEPTH)), "full reported below depth")

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Testbench for arp_cache_table_with_aging: directed and random insert, lookup,
// pop and age-sweep transactions, each result checked against an in-bench cache.
// Depends on arpc_pkg and the arp_cache_table_with_aging RTL.
module tb;
    import arpc_pkg::*;

    localparam int RUN_LIMIT    = 500000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
    localparam int MAX_PRINTED  = 100;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] now;
    } arp_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [IP_W-1:0]      ip;
        logic [MAC_W-1:0]     mac;
        logic [TIME_W-1:0]    stamp;
        logic [REMOVED_W-1:0] removed;
    } arp_reply_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic [MODE_W-1:0]    mode      = '0;
    logic [IP_W-1:0]      ip_addr   = '0;
    logic [MAC_W-1:0]     mac_addr  = '0;
    logic [TIME_W-1:0]    time_now  = '0;
    logic                 cfg_we    = 1'b0;
    logic [TIME_W-1:0]    cfg_wdata = '0;
    logic                 busy;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [IP_W-1:0]      found_ip;
    logic [MAC_W-1:0]     found_mac;
    logic [TIME_W-1:0]    found_stamp;
    logic [REMOVED_W-1:0] removed_count;

    arp_cache_table_with_aging dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .ip_addr       (ip_addr),
        .mac_addr      (mac_addr),
        .time_now      (time_now),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .status        (status),
        .found_ip      (found_ip),
        .found_mac     (found_mac),
        .found_stamp   (found_stamp),
        .removed_count (removed_count)
    );

    always #5 clk = ~clk;

    // Bench copy of the cache: slot 0 oldest, slot cache_fill-1 newest.
    entry_t            cache_entry [DEPTH];
    int                cache_fill      = 0;
    logic [TIME_W-1:0] model_age_limit = AGE_LIMIT_RESET;

    arp_cmd_t          pending_cmds[$];
    arp_reply_t        expected_replies[$];
    int                cmds_queued  = 0;
    int                replies_seen = 0;
    int                error_count  = 0;
    int                cycle_count  = 0;

    logic [IP_W-1:0]   ip_pool [8];
    logic [TIME_W-1:0] gen_clock = TIME_W'(200);

    task automatic report_error(string msg);
        if (error_count < MAX_PRINTED)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic arp_reply_t arp_predict(arp_cmd_t cmd);
        arp_reply_t        rp;
        int                slot;
        int                keep;
        logic [TIME_W-1:0] age;
        rp = '0;
        case (cmd.mode)
            MODE_INSERT:
            begin
                if (cache_fill >= DEPTH)
                    rp.status = STATUS_FULL;
                else
                begin
                    cache_entry[cache_fill] = '{ip: cmd.ip, mac: cmd.mac, stamp: cmd.now};
                    cache_fill++;
                end
            end
            MODE_LOOKUP:
            begin
                // scan newest first
                slot = cache_fill - 1;
                while (slot >= 0 && cache_entry[slot].ip != cmd.ip)
                    slot--;
                if (slot < 0)
                    rp.status = STATUS_MISS;
                else
                begin
                    rp.ip    = cache_entry[slot].ip;
                    rp.mac   = cache_entry[slot].mac;
                    rp.stamp = cache_entry[slot].stamp;
                end
            end
            MODE_POP:
            begin
                if (cache_fill == 0)
                    rp.status = STATUS_MISS;
                else
                begin
                    cache_fill--;
                    rp.ip    = cache_entry[cache_fill].ip;
                    rp.mac   = cache_entry[cache_fill].mac;
                    rp.stamp = cache_entry[cache_fill].stamp;
                end
            end
            default:
            begin
                // compact survivors toward slot 0, keeping their order
                keep = 0;
                for (int j = 0; j < cache_fill; j++)
                begin
                    age = cmd.now - cache_entry[j].stamp;
                    if (age < model_age_limit)
                    begin
                        cache_entry[keep] = cache_entry[j];
                        keep++;
                    end
                end
                rp.removed = REMOVED_W'(cache_fill - keep);
                cache_fill = keep;
            end
        endcase
        return rp;
    endfunction

    // Driver: present queued commands, hold while busy, random gaps between them.
    arp_cmd_t cur_cmd;
    int       gap_left = 0;
    bit       no_gaps  = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n && !(start && busy))
        begin
            if (start)
            begin
                expected_replies.push_back(arp_predict(cur_cmd));
                if ($urandom_range(0, 39) == 0)
                    no_gaps = ~no_gaps;
                gap_left = no_gaps ? 0 : $urandom_range(0, 4);
            end
            if (gap_left == 0 && pending_cmds.size() > 0)
            begin
                cur_cmd = pending_cmds.pop_front();
                start    <= 1'b1;
                mode     <= cur_cmd.mode;
                ip_addr  <= cur_cmd.ip;
                mac_addr <= cur_cmd.mac;
                time_now <= cur_cmd.now;
            end
            else
            begin
                if (gap_left > 0)
                    gap_left--;
                // junk on the payload while start is low
                start    <= 1'b0;
                mode     <= MODE_W'($urandom);
                ip_addr  <= $urandom;
                mac_addr <= MAC_W'({$urandom, $urandom});
                time_now <= $urandom;
            end
        end
    end

    task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %0h, expected %0h",
                                   replies_seen, what, got, want));
    endtask

    // Monitor: every done cycle carries one result.
    arp_reply_t want_reply;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            replies_seen++;
            if (expected_replies.size() == 0)
                report_error("result with no transaction outstanding");
            else
            begin
                want_reply = expected_replies.pop_front();
                check_field("status", 64'(status), 64'(want_reply.status));
                check_field("found_ip", 64'(found_ip), 64'(want_reply.ip));
                check_field("found_mac", 64'(found_mac), 64'(want_reply.mac));
                check_field("found_stamp", 64'(found_stamp), 64'(want_reply.stamp));
                check_field("removed_count", 64'(removed_count), 64'(want_reply.removed));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic queue_cmd(logic [MODE_W-1:0] m, logic [IP_W-1:0] ip,
                             logic [MAC_W-1:0] mac, logic [TIME_W-1:0] now);
        pending_cmds.push_back('{mode: m, ip: ip, mac: mac, now: now});
        cmds_queued++;
    endtask

    task automatic wait_idle();
        while (replies_seen < cmds_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_age_limit(logic [TIME_W-1:0] limit);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_wdata <= $urandom;
        model_age_limit = limit;
    endtask

    task automatic gen_cmd(logic [MODE_W-1:0] m);
        logic [IP_W-1:0]   ip;
        logic [TIME_W-1:0] now;
        gen_clock += $urandom_range(0, 3);
        if ($urandom_range(0, 49) == 0)
            gen_clock += $urandom;
        ip  = ($urandom_range(0, 5) == 0) ? $urandom : ip_pool[$urandom_range(0, 7)];
        now = gen_clock;
        if ($urandom_range(0, 19) == 0)
            now = $urandom;
        else if (m == MODE_AGE && $urandom_range(0, 9) == 0)
            now = gen_clock - $urandom_range(1, 20);
        queue_cmd(m, ip, MAC_W'({$urandom, $urandom}), now);
    endtask

    // Mostly single commands of random kind, with bursts that fill or drain the table.
    task automatic random_phase(int count, bit fill_first);
        int               n;
        int               pick;
        int               burst;
        logic [MODE_W-1:0] kind;
        n = 0;
        while (n < count)
        begin
            pick  = $urandom_range(0, 999);
            burst = 1;
            if (fill_first || pick < 6)
            begin
                burst      = DEPTH + 2;
                kind       = MODE_INSERT;
                fill_first = 1'b0;
            end
            else if (pick < 11)
            begin
                burst = DEPTH + 2;
                kind  = MODE_POP;
            end
            else if (pick < 411)
                kind = MODE_INSERT;
            else if (pick < 711)
                kind = MODE_LOOKUP;
            else if (pick < 861)
                kind = MODE_POP;
            else
                kind = MODE_AGE;
            repeat (burst) gen_cmd(kind);
            n += burst;
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (ip_pool[k])
            ip_pool[k] = $urandom;
        ip_pool[0] = '0;
        ip_pool[1] = '1;

        // empty table, field extremes, duplicate IP, boundary and wrapped ages
        queue_cmd(MODE_POP, '0, '0, '0);
        queue_cmd(MODE_LOOKUP, '0, '0, '0);
        queue_cmd(MODE_AGE, '0, '0, '0);
        queue_cmd(MODE_INSERT, '0, '0, '0);
        queue_cmd(MODE_INSERT, '1, '1, '1);
        queue_cmd(MODE_INSERT, '0, 48'h1234_5678_9abc, 32'd5);
        queue_cmd(MODE_LOOKUP, '0, '1, '1);
        queue_cmd(MODE_LOOKUP, '1, '0, '0);
        queue_cmd(MODE_LOOKUP, 32'h1234_5678, '0, '0);
        queue_cmd(MODE_AGE, '1, '1, 32'd14);
        queue_cmd(MODE_POP, '1, '1, '1);
        queue_cmd(MODE_LOOKUP, '0, '0, '0);
        queue_cmd(MODE_AGE, '0, '0, 32'd15);
        queue_cmd(MODE_POP, '0, '0, '0);
        queue_cmd(MODE_INSERT, 32'hc0a8_0001, 48'h0200_0000_0001, 32'd10);
        queue_cmd(MODE_AGE, '0, '0, 32'd5);
        queue_cmd(MODE_INSERT, 32'h0a00_0001, 48'h8000_0000_0000, 32'd100);
        queue_cmd(MODE_AGE, '0, '0, 32'd114);
        queue_cmd(MODE_LOOKUP, 32'h0a00_0001, '0, '0);
        queue_cmd(MODE_POP, '0, '0, '0);
        random_phase(150, 1'b1);

        set_age_limit(32'd1);
        random_phase(150, 1'b0);

        // with the largest limit only an entry stamped one count ahead of now goes
        set_age_limit('1);
        queue_cmd(MODE_INSERT, 32'h0101_0101, 48'h0000_0000_00ff, 32'd50);
        queue_cmd(MODE_INSERT, 32'h0202_0202, 48'hff00_0000_0000, 32'd49);
        queue_cmd(MODE_AGE, '0, '0, 32'd49);
        queue_cmd(MODE_POP, '0, '0, '0);
        random_phase(120, 1'b1);

        set_age_limit($urandom_range(2, 100));
        random_phase(150, 1'b0);

        set_age_limit(32'd1000);
        random_phase(100, 1'b0);

        set_age_limit(32'd15);
        random_phase(150, 1'b0);

        set_age_limit($urandom | 32'd1);
        random_phase(120, 1'b1);

        while (replies_seen < cmds_queued)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_replies.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_replies.size()));
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

FILE: arp_cache_table_with_aging.f
+incdir+rtl
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arpc_match_unit.sv
rtl/arp_cache_table_with_aging.sv
bench/tb.sv
